FILE: src/wfd_pkg.sv
`default_nettype none
package wfd_pkg;

  typedef enum logic [3:0] {
    PH_HDR0 = 4'b0001,
    PH_HDR1 = 4'b0010,
    PH_EXT  = 4'b0100,
    PH_PAY  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    EV_DATA      = 2'd0,
    EV_EMPTY_END = 2'd1,
    EV_PING      = 2'd2,
    EV_CLOSE     = 2'd3
  } evt_t;

  localparam logic [3:0] OP_LAST_DATA = 4'h2;
  localparam logic [3:0] OP_CLOSE     = 4'h8;
  localparam logic [3:0] OP_PING      = 4'h9;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;

  localparam int unsigned PAY_LEN_W = 64;

  typedef struct packed {
    logic       vld;
    evt_t       evt;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

FILE: src/wfd_in_reg.sv
`default_nettype none
module wfd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_free,
  output logic            step,
  output logic [7:0]      byte_q
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       accept;

  // Hold the stage while the result side cannot take a new result.
  assign in_stall = vld_r && !out_free;
  assign accept   = in_valid && !in_stall;
  assign step     = vld_r && out_free;
  assign byte_q   = byte_r;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (step) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule
`default_nettype wire

FILE: src/wfd_parser.sv
`default_nettype none
module wfd_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  output wfd_pkg::res_t    res
);

  localparam int unsigned PW = wfd_pkg::PAY_LEN_W;

  wfd_pkg::phase_t phase_r, phase_nxt;
  logic            final_r, final_nxt;
  logic [3:0]      opcode_r, opcode_nxt;
  logic [3:0]      ext_left_r, ext_left_nxt;
  logic [PW-1:0]   pay_left_r, pay_left_nxt;

  logic [6:0]      len7;
  logic [PW-1:0]   pay_shift;
  logic [PW-1:0]   pay_dec;
  logic            is_data;

  // Result for a frame whose header ends with an empty payload.
  function automatic wfd_pkg::res_t empty_end(input logic [3:0] op, input logic fin);
    wfd_pkg::res_t r;
    r = '0;
    if (op == wfd_pkg::OP_CLOSE) begin
      r.vld = 1'b1;
      r.evt = wfd_pkg::EV_CLOSE;
    end else if (op == wfd_pkg::OP_PING) begin
      r.vld = 1'b1;
      r.evt = wfd_pkg::EV_PING;
    end else if (op <= wfd_pkg::OP_LAST_DATA && fin) begin
      r.vld  = 1'b1;
      r.evt  = wfd_pkg::EV_EMPTY_END;
      r.last = 1'b1;
    end
    return r;
  endfunction

  assign len7      = rx_byte[6:0];
  assign pay_shift = {pay_left_r[PW-9:0], rx_byte};
  assign pay_dec   = pay_left_r - PW'(1);
  assign is_data   = (opcode_r <= wfd_pkg::OP_LAST_DATA);

  always_comb begin
    phase_nxt    = phase_r;
    final_nxt    = final_r;
    opcode_nxt   = opcode_r;
    ext_left_nxt = ext_left_r;
    pay_left_nxt = pay_left_r;
    res          = '0;
    case (phase_r)
      wfd_pkg::PH_HDR1: begin
        if (len7 == wfd_pkg::LEN_EXT16) begin
          ext_left_nxt = wfd_pkg::EXT16_BYTES;
          pay_left_nxt = '0;
          phase_nxt    = wfd_pkg::PH_EXT;
        end else if (len7 == wfd_pkg::LEN_EXT64) begin
          ext_left_nxt = wfd_pkg::EXT64_BYTES;
          pay_left_nxt = '0;
          phase_nxt    = wfd_pkg::PH_EXT;
        end else begin
          pay_left_nxt = PW'(len7);
          if (len7 == 7'd0) begin
            phase_nxt = wfd_pkg::PH_HDR0;
            res       = empty_end(opcode_r, final_r);
          end else begin
            phase_nxt = wfd_pkg::PH_PAY;
          end
        end
      end
      wfd_pkg::PH_EXT: begin
        pay_left_nxt = pay_shift;
        ext_left_nxt = ext_left_r - 4'd1;
        if (ext_left_nxt == 4'd0) begin
          if (pay_shift == '0) begin
            phase_nxt = wfd_pkg::PH_HDR0;
            res       = empty_end(opcode_r, final_r);
          end else begin
            phase_nxt = wfd_pkg::PH_PAY;
          end
        end
      end
      wfd_pkg::PH_PAY: begin
        pay_left_nxt = pay_dec;
        if (pay_dec == '0) begin
          phase_nxt = wfd_pkg::PH_HDR0;
        end
        if (is_data) begin
          res.vld  = 1'b1;
          res.evt  = wfd_pkg::EV_DATA;
          res.data = rx_byte;
          res.last = (pay_dec == '0) && final_r;
        end else if (pay_dec == '0) begin
          if (opcode_r == wfd_pkg::OP_CLOSE) begin
            res.vld = 1'b1;
            res.evt = wfd_pkg::EV_CLOSE;
          end else if (opcode_r == wfd_pkg::OP_PING) begin
            res.vld = 1'b1;
            res.evt = wfd_pkg::EV_PING;
          end
        end
      end
      default: begin
        final_nxt    = rx_byte[7];
        opcode_nxt   = rx_byte[3:0];
        ext_left_nxt = 4'd0;
        pay_left_nxt = '0;
        phase_nxt    = wfd_pkg::PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wfd_pkg::PH_HDR0;
      final_r    <= 1'b0;
      opcode_r   <= 4'd0;
      ext_left_r <= 4'd0;
      pay_left_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      final_r    <= final_nxt;
      opcode_r   <= opcode_nxt;
      ext_left_r <= ext_left_nxt;
      pay_left_r <= pay_left_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/wfd_out_reg.sv
`default_nettype none
module wfd_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wfd_pkg::res_t      res,
  output logic               out_free,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_event_res,
  output logic [7:0]         out_data_byte,
  output logic               out_last
);

  logic            valid_r;
  logic            valid_nxt;
  wfd_pkg::evt_t   evt_r;
  logic [7:0]      data_r;
  logic            last_r;
  logic            load;

  // Free when empty or when the held result leaves this cycle.
  assign out_free = !valid_r || !out_stall;
  assign load     = out_free && step && res.vld;

  always_comb begin
    valid_nxt = valid_r;
    if (out_free) begin
      valid_nxt = step && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      evt_r  <= res.evt;
      data_r <= res.data;
      last_r <= res.last;
    end
  end

  assign out_valid     = valid_r;
  assign out_event_res = evt_r;
  assign out_data_byte = data_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

FILE: src/websocket_frame_deframer.sv
`default_nettype none
// Path: an accepted byte is registered in the input stage, parsed combinationally,
//   and its result is registered in the result register before it shows on out_*.
// Throughput: one byte per cycle; a result held under out_stall holds the input stage,
//   and out_stall reaches in_stall combinationally, so no cycle is lost on release.
// Reset: synchronous, active low; clears the parser to await a first header byte
//   and empties both the input and the result registers.
module websocket_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_event_res,
  output logic [7:0]      out_data_byte,
  output logic            out_last
);

  // Handshake glue: the input stage steps a byte into the parser only
  // when the result register can take whatever the byte produces.
  logic          out_free;
  logic          step;
  logic [7:0]    byte_q;
  wfd_pkg::res_t res;

  // Capture one received byte per item; stall only while the captured
  // byte cannot advance because a result is still waiting downstream.
  wfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_free   (out_free),
    .step       (step),
    .byte_q     (byte_q)
  );

  // Parse the frame header (FIN, opcode, 7/16/64-bit length), forward
  // data and continuation payload, and reduce ping and close frames to a
  // single event at frame end. Pong and reserved opcodes drop silently.
  wfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_q),
    .res     (res)
  );

  // Hold each result until taken; a byte that yields no result still
  // advances through the parser without touching this register.
  wfd_out_reg u_out_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .res           (res),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

FILE: tb/websocket_frame_deframer_chk.sv
`default_nettype none
module websocket_frame_deframer_chk (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [1:0] out_event_res,
  input  wire logic [7:0] out_data_byte,
  input  wire logic       out_last,
  output int              mismatches,
  output int              pending,
  output int              n_payload,
  output int              n_msg_end,
  output int              n_ping,
  output int              n_close
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    wfd_pkg::evt_t ev;
    logic [7:0]    data;
    logic          last;
  } frame_evt_t;

  // Shadow parser state
  wfd_pkg::phase_t ph;
  logic            fin;
  logic [3:0]      opc;
  logic [3:0]      ext_left;
  logic [63:0]     pay_left;

  frame_evt_t frame_events_q[$];
  int err_cnt, pay_cnt, end_cnt, ping_cnt, close_cnt;

  function automatic bit is_data_op(logic [3:0] op);
    return op <= wfd_pkg::OP_LAST_DATA;
  endfunction

  // Header complete: enter payload, or close out an empty frame.
  task automatic end_of_header(output bit got, output frame_evt_t e);
    got = 1'b0;
    e   = '{ev: wfd_pkg::EV_DATA, data: 8'h00, last: 1'b0};
    if (pay_left != 64'd0) begin
      ph = wfd_pkg::PH_PAY;
    end else begin
      ph = wfd_pkg::PH_HDR0;
      if (opc == wfd_pkg::OP_CLOSE) begin
        got = 1'b1;
        e   = '{ev: wfd_pkg::EV_CLOSE, data: 8'h00, last: 1'b0};
      end else if (opc == wfd_pkg::OP_PING) begin
        got = 1'b1;
        e   = '{ev: wfd_pkg::EV_PING, data: 8'h00, last: 1'b0};
      end else if (is_data_op(opc) && fin) begin
        got = 1'b1;
        e   = '{ev: wfd_pkg::EV_EMPTY_END, data: 8'h00, last: 1'b1};
      end
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    bit         got;
    bit         ends;
    frame_evt_t e;
    got = 1'b0;
    e   = '{ev: wfd_pkg::EV_DATA, data: 8'h00, last: 1'b0};
    case (ph)
      wfd_pkg::PH_HDR1: begin
        if (b[6:0] == wfd_pkg::LEN_EXT16) begin
          ext_left = wfd_pkg::EXT16_BYTES;
          pay_left = 64'd0;
          ph       = wfd_pkg::PH_EXT;
        end else if (b[6:0] == wfd_pkg::LEN_EXT64) begin
          ext_left = wfd_pkg::EXT64_BYTES;
          pay_left = 64'd0;
          ph       = wfd_pkg::PH_EXT;
        end else begin
          pay_left = {57'd0, b[6:0]};
          end_of_header(got, e);
        end
      end
      wfd_pkg::PH_EXT: begin
        pay_left = {pay_left[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) end_of_header(got, e);
      end
      wfd_pkg::PH_PAY: begin
        pay_left = pay_left - 64'd1;
        ends     = (pay_left == 64'd0);
        if (ends) ph = wfd_pkg::PH_HDR0;
        if (is_data_op(opc)) begin
          got = 1'b1;
          e   = '{ev: wfd_pkg::EV_DATA, data: b, last: ends && fin};
        end else if (ends && opc == wfd_pkg::OP_CLOSE) begin
          got = 1'b1;
          e   = '{ev: wfd_pkg::EV_CLOSE, data: 8'h00, last: 1'b0};
        end else if (ends && opc == wfd_pkg::OP_PING) begin
          got = 1'b1;
          e   = '{ev: wfd_pkg::EV_PING, data: 8'h00, last: 1'b0};
        end
      end
      default: begin
        fin      = b[7];
        opc      = b[3:0];
        ext_left = 4'd0;
        pay_left = 64'd0;
        ph       = wfd_pkg::PH_HDR1;
      end
    endcase
    if (got) frame_events_q.push_back(e);
  endtask

  always @(posedge clk) begin
    frame_evt_t exp_e;
    if (!rst_n) begin
      ph       = wfd_pkg::PH_HDR0;
      fin      = 1'b0;
      opc      = 4'd0;
      ext_left = 4'd0;
      pay_left = 64'd0;
      frame_events_q.delete();
    end else begin
      // Compare before predicting: a byte taken now cannot show up at this edge.
      if (out_valid && !out_stall) begin
        if (frame_events_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%t unexpected result: event %0d data %02h last %0b",
                     $realtime, out_event_res, out_data_byte, out_last);
        end else begin
          exp_e = frame_events_q.pop_front();
          if (out_event_res !== exp_e.ev || out_data_byte !== exp_e.data ||
              out_last !== exp_e.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%t mismatch: expected event %0d data %02h last %0b, got %0d %02h %0b",
                       $realtime, exp_e.ev, exp_e.data, exp_e.last,
                       out_event_res, out_data_byte, out_last);
          end
          case (exp_e.ev)
            wfd_pkg::EV_DATA:      pay_cnt++;
            wfd_pkg::EV_EMPTY_END: end_cnt++;
            wfd_pkg::EV_PING:      ping_cnt++;
            default:               close_cnt++;
          endcase
        end
      end
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
    end
    mismatches <= err_cnt;
    pending    <= frame_events_q.size();
    n_payload  <= pay_cnt;
    n_msg_end  <= end_cnt;
    n_ping     <= ping_cnt;
    n_close    <= close_cnt;
  end

endmodule
`default_nettype wire

FILE: tb/websocket_frame_deframer_tb.sv
`default_nettype none
module websocket_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // How a frame header encodes its payload length
  typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_t;
  // Idle behavior of one side, re-drawn now and then
  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

  localparam int N_BYTES    = 1900;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_CYC  = 20;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;
  wire logic       in_stall;
  wire logic       out_valid;
  wire logic [1:0] out_event_res;
  wire logic [7:0] out_data_byte;
  wire logic       out_last;

  int mismatches, pending, n_payload, n_msg_end, n_ping, n_close;
  int n_sent;
  int n_frames;
  idle_mode_t in_mode  = IDLE_FULL;
  idle_mode_t out_mode = IDLE_FULL;

  // Directed stream: data extremes with FIN, a fragmented message closed by an
  // empty FIN continuation, an empty masked ping, a pong, an empty non-FIN
  // binary frame, a close with reserved bits and a 16-bit length, and a
  // reserved opcode with a 64-bit zero length.
  logic [7:0] dir_bytes [31] = '{
    8'h81, 8'h02, 8'h00, 8'hff,
    8'h01, 8'h01, 8'h55,
    8'h80, 8'h00,
    8'h89, 8'h80,
    8'h8a, 8'h01, 8'hff,
    8'h02, 8'h00,
    8'hf8, 8'h7e, 8'h00, 8'h01, 8'hab,
    8'hb3, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  websocket_frame_deframer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

  websocket_frame_deframer_chk chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_data_byte (out_data_byte),
    .out_last      (out_last),
    .mismatches    (mismatches),
    .pending       (pending),
    .n_payload     (n_payload),
    .n_msg_end     (n_msg_end),
    .n_ping        (n_ping),
    .n_close       (n_close)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int draw_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 7);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    endcase
  endfunction

  // Offer one item after a random gap and hold it until it is taken.
  // With no gap, valid stays high and only the payload advances.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_idle(in_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_header(input logic [7:0] hdr, input bit mask, input len_form_t form,
                             input logic [63:0] len);
    send_byte(hdr);
    case (form)
      LEN_SHORT: send_byte({mask, len[6:0]});
      LEN_16: begin
        send_byte({mask, wfd_pkg::LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask, wfd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
  endtask

  // Build one random frame: mostly data, some control, pong and reserved
  // opcodes, random FIN, reserved bits and mask, and all three length forms.
  task automatic send_random_frame();
    int          r;
    int          k;
    logic [3:0]  op;
    logic [2:0]  rsv;
    bit          fin_bit;
    bit          mask;
    len_form_t   form;
    logic [63:0] len;
    r = $urandom_range(0, 99);
    if (r < 70)      op = 4'($urandom_range(0, 2));
    else if (r < 80) op = wfd_pkg::OP_PING;
    else if (r < 88) op = wfd_pkg::OP_CLOSE;
    else if (r < 94) op = 4'hA;
    else begin
      k  = $urandom_range(0, 9);
      op = (k < 5) ? 4'(3 + k) : 4'(11 + k - 5);
    end
    fin_bit = ($urandom_range(0, 9) < 6);
    rsv     = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
    mask    = ($urandom_range(0, 3) == 0);
    k       = $urandom_range(0, 19);
    if (k < 13) begin
      form = LEN_SHORT;
      len  = 64'($urandom_range(0, 12));
    end else if (k == 13) begin
      form = LEN_SHORT;
      len  = 64'($urandom_range(0, 125));
    end else if (k < 17) begin
      form = LEN_16;
      len  = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(120, 300))
                                         : 64'($urandom_range(0, 20));
    end else begin
      form = LEN_64;
      len  = 64'($urandom_range(0, 16));
    end
    send_header({fin_bit, rsv, op}, mask, form, len);
    repeat (int'(len)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Receiver: stall a random number of cycles before each result; after the
  // 300th and 1000th result hold off for a long stretch so the block backs up.
  initial begin
    int stall_n;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 300 || taken == 1000) stall_n = LONG_HOLD;
      else stall_n = draw_idle(out_mode);
      if (stall_n > 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if ($urandom_range(0, 31) == 0) out_mode = idle_mode_t'($urandom_range(0, 2));
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_bytes[i]) send_byte(dir_bytes[i]);

    n_frames = 0;
    while (n_sent < N_BYTES) begin
      send_random_frame();
      n_frames++;
      if ($urandom_range(0, 15) == 0) in_mode = idle_mode_t'($urandom_range(0, 2));
    end

    // Finish with a data frame whose 64-bit length never runs out: every byte
    // must still come out as payload without a spurious end.
    send_byte(8'h82);
    send_byte({1'b1, wfd_pkg::LEN_EXT64});
    send_byte(8'($urandom_range(1, 255)));
    repeat (7) send_byte(8'($urandom_range(0, 255)));
    repeat (40) send_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d bytes in %0d random frames plus directed ones.", n_sent, n_frames);
    $display("Seen: %0d payload bytes, %0d empty message ends, %0d pings, %0d closes.",
             n_payload, n_msg_end, n_ping, n_close);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
src/wfd_pkg.sv
src/wfd_in_reg.sv
src/wfd_parser.sv
src/wfd_out_reg.sv
src/websocket_frame_deframer.sv
tb/websocket_frame_deframer_chk.sv
tb/websocket_frame_deframer_tb.sv
